### hdl/efsa_pkg.sv
// ----------------------------------------------------------------------------
// efsa_pkg: shared types and constants of the earliest free server assigner
// Widths, reset values, register indexes, controller states and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package efsa_pkg;

  // Built pool size and derived index and count widths
  localparam int unsigned MAX_SERVERS = 128;
  localparam int unsigned IDX_W       = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam int unsigned CNT_W       = $clog2(MAX_SERVERS + 1);

  // Field widths
  localparam int unsigned TIME_W  = 17;
  localparam int unsigned SVC_W   = 8;
  localparam int unsigned SRV_W   = 8;
  localparam int unsigned FREE_W  = 24;
  localparam int unsigned SUM_W   = 40;
  localparam int unsigned JOBS_W  = 16;
  localparam int unsigned OIDX_W  = 7;
  localparam int unsigned PROD_W  = 14;
  localparam int unsigned CMP_W   = (SRV_W > CNT_W) ? SRV_W : CNT_W;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 17;

  // Reset values and time constants
  localparam logic [SRV_W-1:0]  NUM_SERVERS_RST = SRV_W'(1);
  localparam logic [TIME_W-1:0] OPEN_TIME_RST   = TIME_W'(8 * 3600);
  localparam logic [TIME_W-1:0] CLOSE_TIME_RST  = TIME_W'(17 * 3600);
  localparam logic [5:0]        SECS_PER_MIN    = 6'd60;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_SERVERS = 2'd0,
    CFG_OPEN_TIME   = 2'd1,
    CFG_CLOSE_TIME  = 2'd2
  } efsa_cfg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_CALC,
    S_COMMIT
  } efsa_state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;    // latch the input word, start a new scan
    logic issue;   // read the next free time
    logic calc;    // form wait and new free time
    logic commit;  // write back, update totals, load the result word
  } efsa_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic reject;     // incoming word is refused
    logic scan_last;  // current read address is the last server in use
    logic out_free;   // result register can take a word this cycle
  } efsa_status_t;

endpackage

### hdl/efsa_ram.sv
// ----------------------------------------------------------------------------
// efsa_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module efsa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/efsa_ctrl.sv
// ----------------------------------------------------------------------------
// efsa_ctrl: sequencing controller of the earliest free server assigner
// Steps one job: accept, scan, drain, calc, commit; a refusal goes to commit.
// ----------------------------------------------------------------------------
module efsa_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  efsa_pkg::efsa_status_t status_i,
  output efsa_pkg::efsa_cmd_t    cmd_o
);

  import efsa_pkg::*;

  efsa_state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = status_i.reject ? S_COMMIT : S_SCAN;
        end
      end
      S_SCAN: begin
        if (status_i.scan_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN:  state_d = S_CALC;
      S_CALC:   state_d = S_COMMIT;
      S_COMMIT: begin
        if (status_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default:  state_d = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      S_SCAN:   cmd_o.issue  = 1'b1;
      S_DRAIN:  cmd_o        = '0;
      S_CALC:   cmd_o.calc   = 1'b1;
      S_COMMIT: cmd_o.commit = status_i.out_free;
      default:  cmd_o        = '0;
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### hdl/efsa_dp.sv
// ----------------------------------------------------------------------------
// efsa_dp: datapath of the earliest free server assigner
// Configuration registers, free-time RAM with valid bits, minimum scan,
// wait and free-time arithmetic, saturating totals and the result register.
// ----------------------------------------------------------------------------
module efsa_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Configuration
  input  logic                                 cfg_we_i,
  input  logic [efsa_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [efsa_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  // Input word
  input  logic [efsa_pkg::TIME_W-1:0]          arrival_time_i,
  input  logic [efsa_pkg::SVC_W-1:0]           service_minutes_i,
  input  logic                                 last_job_i,
  // Result word
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 accepted_o,
  output logic [efsa_pkg::OIDX_W-1:0]          server_index_o,
  output logic [efsa_pkg::FREE_W-1:0]          wait_seconds_o,
  output logic [efsa_pkg::SUM_W-1:0]           total_wait_o,
  output logic [efsa_pkg::JOBS_W-1:0]          served_count_o,
  output logic                                 final_res_o,
  // Controller link
  input  efsa_pkg::efsa_cmd_t                  cmd_i,
  output efsa_pkg::efsa_status_t               status_o
);

  import efsa_pkg::*;

  // Configuration registers
  logic [SRV_W-1:0]  num_servers_q;
  logic [TIME_W-1:0] open_time_q;
  logic [TIME_W-1:0] close_time_q;

  // Job state
  logic [TIME_W-1:0] arr_q;
  logic [SVC_W-1:0]  svc_q;
  logic              last_q;
  logic              rej_q;
  logic              closed_q;

  // Scan state
  logic [IDX_W-1:0]  rd_idx_q;
  logic              cmp_vld_q;
  logic [IDX_W-1:0]  cmp_idx_q;
  logic              cmp_vbit_q;
  logic              first_q;
  logic [FREE_W-1:0] best_t_q;
  logic [IDX_W-1:0]  best_idx_q;

  // Arithmetic results
  logic [FREE_W-1:0] wait_q;
  logic [FREE_W-1:0] nf_q;

  // Free-time valid bits and totals
  logic [MAX_SERVERS-1:0] valid_q;
  logic [SUM_W-1:0]       wait_sum_q;
  logic [JOBS_W-1:0]      job_count_q;

  // Result register
  logic              out_valid_q;
  logic              out_acc_q;
  logic [OIDX_W-1:0] out_idx_q;
  logic [FREE_W-1:0] out_wait_q;
  logic [SUM_W-1:0]  out_total_q;
  logic [JOBS_W-1:0] out_count_q;
  logic              out_final_q;

  logic [FREE_W-1:0] rd_data;
  logic [CMP_W-1:0]  ns_ext;
  logic [CNT_W-1:0]  n_servers;
  logic [FREE_W-1:0] open_ext;
  logic [FREE_W-1:0] rd_ext;
  logic [FREE_W-1:0] eff_t;
  logic [FREE_W-1:0] arr_ext;
  logic [FREE_W-1:0] start_t;
  logic [FREE_W-1:0] wait_d;
  logic [PROD_W-1:0] svc_secs;
  logic [FREE_W:0]   nf_sum;
  logic [FREE_W-1:0] nf_d;
  logic [SUM_W:0]    sum_ext;
  logic [SUM_W-1:0]  wait_sum_d;
  logic [JOBS_W-1:0] job_count_d;
  logic              ram_we;

  // Clamp the server count into one to the built maximum
  always_comb begin
    ns_ext = CMP_W'(num_servers_q);
    if (ns_ext == '0) begin
      n_servers = CNT_W'(1);
    end else if (ns_ext > CMP_W'(MAX_SERVERS)) begin
      n_servers = CNT_W'(MAX_SERVERS);
    end else begin
      n_servers = CNT_W'(ns_ext);
    end
  end

  // Status toward the controller
  assign status_o.reject    = closed_q | (arrival_time_i > close_time_q);
  assign status_o.scan_last = (CNT_W'(rd_idx_q) == (n_servers - CNT_W'(1)));
  assign status_o.out_free  = ~out_valid_q | out_ready_i;

  // Free-time store
  assign ram_we = cmd_i.commit & ~rej_q;

  efsa_ram #(
    .WIDTH (FREE_W),
    .DEPTH (MAX_SERVERS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (best_idx_q),
    .wdata_i (nf_q),
    .re_i    (cmd_i.issue),
    .raddr_i (rd_idx_q),
    .rdata_o (rd_data)
  );

  // Effective free time of the word just read
  always_comb begin
    open_ext = FREE_W'(open_time_q);
    rd_ext   = cmp_vbit_q ? rd_data : '0;
    eff_t    = (rd_ext > open_ext) ? rd_ext : open_ext;
  end

  // Start, wait and new free time of the chosen server
  always_comb begin
    arr_ext  = FREE_W'(arr_q);
    start_t  = (best_t_q > arr_ext) ? best_t_q : arr_ext;
    wait_d   = (best_t_q > arr_ext) ? (best_t_q - arr_ext) : '0;
    svc_secs = PROD_W'(svc_q) * PROD_W'(SECS_PER_MIN);
    nf_sum   = (FREE_W + 1)'(start_t) + (FREE_W + 1)'(svc_secs);
    nf_d     = nf_sum[FREE_W] ? '1 : nf_sum[FREE_W-1:0];
  end

  // Saturating totals
  always_comb begin
    sum_ext    = (SUM_W + 1)'(wait_sum_q) + (SUM_W + 1)'(wait_q);
    wait_sum_d = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
    job_count_d = (job_count_q == '1) ? job_count_q : job_count_q + JOBS_W'(1);
  end

  // Control registers: configuration, scan flags, valid bits, totals
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_servers_q <= NUM_SERVERS_RST;
      open_time_q   <= OPEN_TIME_RST;
      close_time_q  <= CLOSE_TIME_RST;
      closed_q      <= 1'b0;
      rej_q         <= 1'b0;
      rd_idx_q      <= '0;
      cmp_vld_q     <= 1'b0;
      first_q       <= 1'b0;
      valid_q       <= '0;
      wait_sum_q    <= '0;
      job_count_q   <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      // Take configuration writes, drop unknown indexes
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_NUM_SERVERS: num_servers_q <= cfg_wdata_i[SRV_W-1:0];
          CFG_OPEN_TIME:   open_time_q   <= cfg_wdata_i[TIME_W-1:0];
          CFG_CLOSE_TIME:  close_time_q  <= cfg_wdata_i[TIME_W-1:0];
          default:         num_servers_q <= num_servers_q;
        endcase
      end
      // Start a new job
      if (cmd_i.load) begin
        rej_q    <= status_o.reject;
        closed_q <= status_o.reject;
        rd_idx_q <= '0;
        first_q  <= 1'b1;
      end
      // Advance the read address
      if (cmd_i.issue) begin
        rd_idx_q <= rd_idx_q + IDX_W'(1);
      end
      cmp_vld_q <= cmd_i.issue;
      if (cmp_vld_q) begin
        first_q <= 1'b0;
      end
      // Write back and count
      if (ram_we) begin
        valid_q[best_idx_q] <= 1'b1;
        wait_sum_q          <= wait_sum_d;
        job_count_q         <= job_count_d;
      end
      // Hold the result word until taken
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      arr_q <= arrival_time_i;
      svc_q <= service_minutes_i;
      last_q <= last_job_i;
    end
    if (cmd_i.issue) begin
      cmp_idx_q  <= rd_idx_q;
      cmp_vbit_q <= valid_q[rd_idx_q];
    end
    // Keep the earliest free time, lowest index on ties
    if (cmp_vld_q && (first_q || (eff_t < best_t_q))) begin
      best_t_q   <= eff_t;
      best_idx_q <= cmp_idx_q;
    end
    if (cmd_i.calc) begin
      wait_q <= wait_d;
      nf_q   <= nf_d;
    end
    if (cmd_i.commit) begin
      out_acc_q   <= ~rej_q;
      out_idx_q   <= rej_q ? '0 : OIDX_W'(best_idx_q);
      out_wait_q  <= rej_q ? '0 : wait_q;
      out_total_q <= rej_q ? wait_sum_q : wait_sum_d;
      out_count_q <= rej_q ? job_count_q : job_count_d;
      out_final_q <= last_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign accepted_o     = out_acc_q;
  assign server_index_o = out_idx_q;
  assign wait_seconds_o = out_wait_q;
  assign total_wait_o   = out_total_q;
  assign served_count_o = out_count_q;
  assign final_res_o    = out_final_q;

endmodule

### hdl/earliest_free_server_assigner.sv
// ----------------------------------------------------------------------------
// earliest_free_server_assigner: first-come first-served job to server mapper
// An accepted job passes through scan, drain and calculate to commit, which
// loads its result word: the scan reads one stored free time per cycle from
// the single RAM read port over the servers in use. A refused job goes
// from acceptance straight to commit; commit waits for the result register.
// Reset is asynchronous, active low; it restores the configuration, clears all
// free times through valid bits, the totals and the closed flag at once.
// ----------------------------------------------------------------------------
module earliest_free_server_assigner (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration write port
  input  logic                            cfg_we_i,
  input  logic [efsa_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [efsa_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // Input channel
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [efsa_pkg::TIME_W-1:0]     arrival_time_i,
  input  logic [efsa_pkg::SVC_W-1:0]      service_minutes_i,
  input  logic                            last_job_i,
  // Output channel
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            accepted_o,
  output logic [efsa_pkg::OIDX_W-1:0]     server_index_o,
  output logic [efsa_pkg::FREE_W-1:0]     wait_seconds_o,
  output logic [efsa_pkg::SUM_W-1:0]      total_wait_o,
  output logic [efsa_pkg::JOBS_W-1:0]     served_count_o,
  output logic                            final_res_o
);

  import efsa_pkg::*;

  efsa_cmd_t    cmd;
  efsa_status_t status;

  // Sequencer
  efsa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Datapath
  efsa_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .arrival_time_i    (arrival_time_i),
    .service_minutes_i (service_minutes_i),
    .last_job_i        (last_job_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .accepted_o        (accepted_o),
    .server_index_o    (server_index_o),
    .wait_seconds_o    (wait_seconds_o),
    .total_wait_o      (total_wait_o),
    .served_count_o    (served_count_o),
    .final_res_o       (final_res_o),
    .cmd_i             (cmd),
    .status_o          (status)
  );

endmodule

### hdl/efsa_checker.sv
// ----------------------------------------------------------------------------
// efsa_assert: port-level assertions for the earliest free server assigner
// Watches the top-level ports only; attached by a bind statement.
// ----------------------------------------------------------------------------
module efsa_assert (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic                        accepted_o,
  input logic [efsa_pkg::OIDX_W-1:0] server_index_o,
  input logic [efsa_pkg::FREE_W-1:0] wait_seconds_o,
  input logic [efsa_pkg::SUM_W-1:0]  total_wait_o,
  input logic [efsa_pkg::JOBS_W-1:0] served_count_o
);

  import efsa_pkg::*;

  // A stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(total_wait_o)
      && $stable(served_count_o) && $stable(accepted_o))
    else $error("result word changed while stalled");

  // One job at a time: busy right after taking a word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken on two consecutive cycles");

  // A refused job carries no server and no wait
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !accepted_o |-> server_index_o == '0 && wait_seconds_o == '0)
    else $error("refused job shows a server or a wait");

  // A served job is counted and its wait is inside the running total
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && accepted_o |-> served_count_o != '0
      && SUM_W'(wait_seconds_o) <= total_wait_o)
    else $error("served job totals inconsistent");

endmodule

bind earliest_free_server_assigner efsa_assert u_efsa_assert (.*);
